[hw/rtl/hbwe_pkg.sv]
// Shared constants, phase codes and the header name table for the body window extractor.
package hbwe_pkg;

    // Length counter width and slot limits
    localparam int LEN_W      = 32;
    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_CNT_W = 5;
    localparam int SLOT_IDX_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Counter widths of the serial divide and multiply
    localparam int DIV_CNT_W = $clog2(LEN_W);
    localparam int MUL_CNT_W = $clog2(SLOT_IDX_W);
    localparam int ACC_W     = LEN_W + SLOT_IDX_W;

    // Header name search
    localparam int NAME_LEN   = 14;
    localparam int NAME_POS_W = 5;

    // Phase codes seen on the phase output
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PASS   = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_INDEX = 1'b1;

    // Characters
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Dividend, clamped divisor and index handed to the slice calculator
    typedef struct packed {
        logic [LEN_W-1:0]      dividend;
        logic [SLOT_CNT_W-1:0] divisor;
        logic [SLOT_IDX_W-1:0] index;
    } calc_req_t;

    // Character expected at each position of "Content-Length"
    function automatic logic [7:0] name_char(input logic [NAME_POS_W-1:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                5'd0:    ch = 8'h43; // C
                5'd1:    ch = 8'h6F; // o
                5'd2:    ch = 8'h6E; // n
                5'd3:    ch = 8'h74; // t
                5'd4:    ch = 8'h65; // e
                5'd5:    ch = 8'h6E; // n
                5'd6:    ch = 8'h74; // t
                5'd7:    ch = 8'h2D; // -
                5'd8:    ch = 8'h4C; // L
                5'd9:    ch = 8'h65; // e
                5'd10:   ch = 8'h6E; // n
                5'd11:   ch = 8'h67; // g
                5'd12:   ch = 8'h74; // t
                5'd13:   ch = 8'h68; // h
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

[hw/rtl/hbwe_slice_calc.sv]
// Bit-serial slice size divider and offset multiplier run once at the end of the header.
module hbwe_slice_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  hbwe_pkg::calc_req_t           req,
    output logic                          done,
    output logic [hbwe_pkg::LEN_W-1:0]    slice_size,
    output logic [hbwe_pkg::LEN_W-1:0]    slice_offset
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [hbwe_pkg::DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic [hbwe_pkg::MUL_CNT_W-1:0]      mul_cnt_reg, mul_cnt_next;
    logic                                done_reg, done_next;
    logic [hbwe_pkg::LEN_W-1:0]          quo_reg, quo_next;
    logic [hbwe_pkg::SLOT_CNT_W-2:0]     rem_reg, rem_next;
    logic [hbwe_pkg::SLOT_CNT_W-1:0]     divisor_reg, divisor_next;
    logic [hbwe_pkg::SLOT_IDX_W-1:0]     index_reg, index_next;
    logic [hbwe_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [hbwe_pkg::LEN_W-1:0]          offset_reg, offset_next;
    logic [hbwe_pkg::SLOT_CNT_W-1:0]     rem_shift;
    logic [hbwe_pkg::SLOT_CNT_W-1:0]     rem_diff;
    logic                                quo_bit;
    logic [hbwe_pkg::ACC_W-1:0]          acc_shift;
    logic [hbwe_pkg::ACC_W-1:0]          addend;
    logic [hbwe_pkg::ACC_W-1:0]          acc_sum;
    logic [hbwe_pkg::MUL_CNT_W-1:0]      bit_sel;

    // One restoring division step and one shift-add step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[hbwe_pkg::LEN_W-1]};
        quo_bit   = (rem_shift >= divisor_reg);
        rem_diff  = rem_shift - divisor_reg;
        bit_sel   = hbwe_pkg::MUL_CNT_W'(hbwe_pkg::SLOT_IDX_W - 1) - mul_cnt_reg;
        acc_shift = {acc_reg[hbwe_pkg::ACC_W-2:0], 1'b0};
        addend    = index_reg[bit_sel] ? {{hbwe_pkg::SLOT_IDX_W{1'b0}}, quo_reg}
                                       : '0;
        acc_sum   = acc_shift + addend;
    end

    // Sequence division then multiplication
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        mul_cnt_next = mul_cnt_reg;
        done_next    = 1'b0;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        index_next   = index_reg;
        acc_next     = acc_reg;
        offset_next  = offset_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    quo_next     = req.dividend;
                    rem_next     = '0;
                    divisor_next = req.divisor;
                    index_next   = req.index;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // shift one dividend bit in, one quotient bit out
                rem_next = quo_bit ? rem_diff[hbwe_pkg::SLOT_CNT_W-2:0]
                                   : rem_shift[hbwe_pkg::SLOT_CNT_W-2:0];
                quo_next = {quo_reg[hbwe_pkg::LEN_W-2:0], quo_bit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == hbwe_pkg::DIV_CNT_W'(hbwe_pkg::LEN_W - 1))
                begin
                    acc_next     = '0;
                    mul_cnt_next = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // Horner over index bits, most significant first
                acc_next     = acc_sum;
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == hbwe_pkg::MUL_CNT_W'(hbwe_pkg::SLOT_IDX_W - 1))
                begin
                    // saturate the offset at the length maximum
                    offset_next = (|acc_sum[hbwe_pkg::ACC_W-1:hbwe_pkg::LEN_W])
                                  ? '1 : acc_sum[hbwe_pkg::LEN_W-1:0];
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            mul_cnt_reg <= '0;
            done_reg    <= 1'b0;
            quo_reg     <= '0;
            offset_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            mul_cnt_reg <= mul_cnt_next;
            done_reg    <= done_next;
            quo_reg     <= quo_next;
            offset_reg  <= offset_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        index_reg   <= index_next;
        acc_reg     <= acc_next;
    end

    assign done         = done_reg;
    assign slice_size   = quo_reg;
    assign slice_offset = offset_reg;

endmodule

[hw/rtl/http_body_window_extractor.sv]
// Top level: HTTP header parser and body slice pass-through.
//
// Takes one response byte per request and returns one result per byte. The byte that
// ends the header (a one-character line closed by LF) with a length found holds the
// input until its result is ready: the slice size comes from a bit-serial restoring
// divider that retires one quotient bit per cycle, followed by a four-step shift-add
// for the offset; then the body phase is picked and the result is loaded once the
// result slot is free. A single result register sits on the output; a new byte is
// taken only when that register is empty or its result leaves in the same cycle.
// slot_count and slot_index are sampled at the header end only.
module http_body_window_extractor (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [hbwe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbwe_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input bytes
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    // results
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [7:0]                          out_byte,
    output logic                                out_valid,
    output logic                                out_last,
    output logic [2:0]                          phase
);

    localparam logic [1:0] CT_READY = 2'd0;
    localparam logic [1:0] CT_CALC  = 2'd1;
    localparam logic [1:0] CT_FIN   = 2'd2;

    logic [1:0]                          ctrl_reg, ctrl_next;
    logic [2:0]                          phase_reg, phase_next;
    logic [hbwe_pkg::NAME_POS_W-1:0]     name_pos_reg, name_pos_next;
    logic                                digits_reg, digits_next;
    logic [1:0]                          line_cnt_reg, line_cnt_next;
    logic [hbwe_pkg::LEN_W-1:0]          body_len_reg, body_len_next;
    logic [hbwe_pkg::LEN_W-1:0]          body_pos_reg, body_pos_next;
    logic [hbwe_pkg::SLOT_CNT_W-1:0]     slot_count_reg;
    logic [hbwe_pkg::SLOT_IDX_W-1:0]     slot_index_reg;
    logic                                res_vld_reg, res_vld_next;
    logic [7:0]                          out_byte_reg, out_byte_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                out_last_reg, out_last_next;
    logic [2:0]                          out_phase_reg, out_phase_next;

    logic                                accept;
    logic                                out_free;
    logic                                is_digit;
    logic                                do_search;
    logic [hbwe_pkg::ACC_W-1:0]          len_times_ten;
    logic [hbwe_pkg::LEN_W-1:0]          pos_inc;
    logic [hbwe_pkg::SLOT_CNT_W-1:0]     divisor_clamp;
    logic                                calc_start;
    hbwe_pkg::calc_req_t                 calc_req;
    logic                                calc_done;
    logic [hbwe_pkg::LEN_W-1:0]          slice_size;
    logic [hbwe_pkg::LEN_W-1:0]          slice_offset;

    // Take a request only when idle and the result slot frees up
    assign out_free = !res_vld_reg || !result_stall;
    assign in_stall = !((ctrl_reg == CT_READY) && out_free);
    assign accept   = in_valid && !in_stall;

    // Clamp slot count to 1..MAX_SLOTS
    always_comb
    begin
        if (slot_count_reg == '0)
            divisor_clamp = hbwe_pkg::SLOT_CNT_W'(1);
        else if (slot_count_reg > hbwe_pkg::SLOT_CNT_W'(hbwe_pkg::MAX_SLOTS))
            divisor_clamp = hbwe_pkg::SLOT_CNT_W'(hbwe_pkg::MAX_SLOTS);
        else
            divisor_clamp = slot_count_reg;
    end

    assign calc_req.dividend = body_len_reg;
    assign calc_req.divisor  = divisor_clamp;
    assign calc_req.index    = slot_index_reg;

    // Per-byte header and body processing
    always_comb
    begin
        ctrl_next      = ctrl_reg;
        phase_next     = phase_reg;
        name_pos_next  = name_pos_reg;
        digits_next    = digits_reg;
        line_cnt_next  = line_cnt_reg;
        body_len_next  = body_len_reg;
        body_pos_next  = body_pos_reg;
        res_vld_next   = res_vld_reg && result_stall;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_phase_next = out_phase_reg;
        calc_start     = 1'b0;
        do_search      = 1'b0;
        is_digit       = (rx_byte >= hbwe_pkg::CHAR_ZERO) && (rx_byte <= hbwe_pkg::CHAR_NINE);
        len_times_ten  = {{hbwe_pkg::SLOT_IDX_W-1{1'b0}}, body_len_reg, 1'b0}
                       + {1'b0, body_len_reg, 3'b000}
                       + hbwe_pkg::ACC_W'(rx_byte - hbwe_pkg::CHAR_ZERO);
        pos_inc        = body_pos_reg + 1'b1;

        case (ctrl_reg)
            CT_READY:
            begin
                if (accept)
                begin
                    out_byte_next  = 8'h00;
                    out_valid_next = 1'b0;
                    out_last_next  = 1'b0;
                    res_vld_next   = 1'b1;
                    case (phase_reg)
                        hbwe_pkg::PH_HEADER:
                        begin
                            // accumulate digits, saturating at the length maximum
                            if (digits_reg)
                            begin
                                if (is_digit)
                                begin
                                    if (|len_times_ten[hbwe_pkg::ACC_W-1:hbwe_pkg::LEN_W])
                                        body_len_next = '1;
                                    else
                                        body_len_next = len_times_ten[hbwe_pkg::LEN_W-1:0];
                                end
                                else
                                begin
                                    digits_next = 1'b0;
                                    do_search   = (body_len_reg == '0);
                                end
                            end
                            else
                            begin
                                do_search = (body_len_reg == '0);
                            end

                            // advance the name match
                            if (do_search)
                            begin
                                if (name_pos_reg < hbwe_pkg::NAME_POS_W'(hbwe_pkg::NAME_LEN))
                                begin
                                    if (rx_byte == hbwe_pkg::name_char(name_pos_reg))
                                        name_pos_next = name_pos_reg + 1'b1;
                                    else if (rx_byte == hbwe_pkg::name_char('0))
                                        name_pos_next = hbwe_pkg::NAME_POS_W'(1);
                                    else
                                        name_pos_next = '0;
                                end
                                else if (name_pos_reg ==
                                         hbwe_pkg::NAME_POS_W'(hbwe_pkg::NAME_LEN))
                                begin
                                    name_pos_next = hbwe_pkg::NAME_POS_W'(hbwe_pkg::NAME_LEN + 1);
                                end
                                else
                                begin
                                    name_pos_next = '0;
                                    digits_next   = 1'b1;
                                end
                            end

                            // track line length, detect the header end
                            if (rx_byte == hbwe_pkg::CHAR_LF)
                            begin
                                line_cnt_next = '0;
                                if (line_cnt_reg == 2'd1)
                                begin
                                    digits_next   = 1'b0;
                                    name_pos_next = '0;
                                    if (body_len_reg == '0)
                                    begin
                                        phase_next = hbwe_pkg::PH_ERROR;
                                    end
                                    else
                                    begin
                                        // hold the result until the slice is computed
                                        calc_start    = 1'b1;
                                        body_pos_next = '0;
                                        res_vld_next  = res_vld_reg && result_stall;
                                        ctrl_next     = CT_CALC;
                                    end
                                end
                            end
                            else if (line_cnt_reg < 2'd2)
                            begin
                                line_cnt_next = line_cnt_reg + 1'b1;
                            end
                        end
                        hbwe_pkg::PH_SKIP:
                        begin
                            if (pos_inc >= slice_offset)
                            begin
                                body_pos_next = '0;
                                phase_next    = hbwe_pkg::PH_PASS;
                            end
                            else
                            begin
                                body_pos_next = pos_inc;
                            end
                        end
                        hbwe_pkg::PH_PASS:
                        begin
                            out_byte_next  = rx_byte;
                            out_valid_next = 1'b1;
                            body_pos_next  = pos_inc;
                            if (pos_inc >= slice_size)
                            begin
                                out_last_next = 1'b1;
                                phase_next    = hbwe_pkg::PH_DONE;
                            end
                        end
                        hbwe_pkg::PH_DONE:
                        begin
                            phase_next = hbwe_pkg::PH_DONE;
                        end
                        default:
                        begin
                            phase_next = hbwe_pkg::PH_ERROR;
                        end
                    endcase
                    out_phase_next = phase_next;
                end
            end
            CT_CALC:
            begin
                // pick the body phase from size and offset
                if (calc_done)
                begin
                    if (slice_size == '0)
                        phase_next = hbwe_pkg::PH_DONE;
                    else if (slice_offset == '0)
                        phase_next = hbwe_pkg::PH_PASS;
                    else
                        phase_next = hbwe_pkg::PH_SKIP;
                    ctrl_next = CT_FIN;
                end
            end
            CT_FIN:
            begin
                // deliver the header-end result once the slot is free
                if (out_free)
                begin
                    res_vld_next   = 1'b1;
                    out_byte_next  = 8'h00;
                    out_valid_next = 1'b0;
                    out_last_next  = 1'b0;
                    out_phase_next = phase_reg;
                    ctrl_next      = CT_READY;
                end
            end
            default:
            begin
                ctrl_next = CT_READY;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg     <= CT_READY;
            phase_reg    <= hbwe_pkg::PH_HEADER;
            name_pos_reg <= '0;
            digits_reg   <= 1'b0;
            line_cnt_reg <= '0;
            body_len_reg <= '0;
            body_pos_reg <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            ctrl_reg     <= ctrl_next;
            phase_reg    <= phase_next;
            name_pos_reg <= name_pos_next;
            digits_reg   <= digits_next;
            line_cnt_reg <= line_cnt_next;
            body_len_reg <= body_len_next;
            body_pos_reg <= body_pos_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= hbwe_pkg::SLOT_CNT_W'(2);
            slot_index_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hbwe_pkg::CFG_SLOT_COUNT:
                    slot_count_reg <= cfg_data;
                hbwe_pkg::CFG_SLOT_INDEX:
                    slot_index_reg <= cfg_data[hbwe_pkg::SLOT_IDX_W-1:0];
                default:
                    slot_count_reg <= slot_count_reg;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_valid_reg <= out_valid_next;
        out_last_reg  <= out_last_next;
        out_phase_reg <= out_phase_next;
    end

    hbwe_slice_calc u_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (calc_start),
        .req          (calc_req),
        .done         (calc_done),
        .slice_size   (slice_size),
        .slice_offset (slice_offset)
    );

    assign result_valid = res_vld_reg;
    assign out_byte     = out_byte_reg;
    assign out_valid    = out_valid_reg;
    assign out_last     = out_last_reg;
    assign phase        = out_phase_reg;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the HTTP body window extractor: header scan, slicing, handshakes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 100000;
    localparam int          ITEM_TARGET  = 400;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          BODY_CAP     = 300;
    localparam logic [63:0] LEN_MAX      = (64'd1 << hbwe_pkg::LEN_W) - 64'd1;
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam string       LENGTH_FIELD = "Content-Length";

    // One result as seen on the output ports
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [2:0] ph;
    } slice_res_t;

    // Directed row: byte to send, and the result when it is typed in
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        slice_res_t res;
    } dir_row_t;

    typedef enum int {
        HC_NORMAL,
        HC_PAST_END,
        HC_ZERO_SLICE,
        HC_NO_LENGTH,
        HC_OVERFLOW
    } hdr_case_t;

    localparam slice_res_t HDR_QUIET = '{data: 8'h00, valid: 1'b0, last: 1'b0,
                                         ph: hbwe_pkg::PH_HEADER};

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // byte extremes inside the header
        '{8'h00, 1'b1, HDR_QUIET},
        '{8'hFF, 1'b1, HDR_QUIET},
        // name match restarts on a second C
        '{"C", 1'b0, '0},
        '{"o", 1'b0, '0},
        '{"C", 1'b0, '0},
        '{"n", 1'b0, '0},
        '{CHAR_CR, 1'b1, HDR_QUIET},
        '{hbwe_pkg::CHAR_LF, 1'b1, HDR_QUIET},
        // empty line does not end the header
        '{hbwe_pkg::CHAR_LF, 1'b1, HDR_QUIET},
        // digit outside a length field
        '{"9", 1'b1, HDR_QUIET},
        '{CHAR_CR, 1'b1, HDR_QUIET},
        '{hbwe_pkg::CHAR_LF, 1'b1, HDR_QUIET},
        // truncated field name
        '{"C", 1'b0, '0},
        '{"o", 1'b0, '0},
        '{"n", 1'b0, '0},
        '{"t", 1'b0, '0},
        '{"e", 1'b0, '0},
        '{"n", 1'b0, '0},
        '{"t", 1'b0, '0},
        '{"-", 1'b0, '0},
        '{"L", 1'b0, '0},
        '{"e", 1'b0, '0},
        '{CHAR_CR, 1'b1, HDR_QUIET},
        '{hbwe_pkg::CHAR_LF, 1'b1, HDR_QUIET}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [hbwe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hbwe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      rx_byte;
    logic                            result_valid;
    logic                            result_stall;
    logic [7:0]                      out_byte;
    logic                            out_valid;
    logic                            out_last;
    logic [2:0]                      phase;

    // Predicted extractor state
    logic [2:0]  exp_phase;
    int          name_pos;
    bit          in_digits;
    int          line_len;
    logic [63:0] body_len;
    logic [63:0] slice_len;
    logic [63:0] slice_start;
    logic [63:0] body_pos;
    logic [4:0]  slot_count_reg;
    logic [3:0]  slot_index_reg;

    slice_res_t  pending_res_q[$];
    slice_res_t  want_res;
    logic [7:0]  line_q[$];
    int          err_count;
    int          n_sent;
    int          tx_pct;
    int          rx_pct;
    bit          hold_go;
    bit          hold_on;

    http_body_window_extractor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .out_last     (out_last),
        .phase        (phase)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Clamp the slot count into the supported range
    function automatic int slots_used(input int cnt);
        return (cnt == 0) ? 1 : (cnt > hbwe_pkg::MAX_SLOTS) ? hbwe_pkg::MAX_SLOTS : cnt;
    endfunction

    // Advance the search for the length field name
    function automatic void track_name(input logic [7:0] c);
        if (name_pos < hbwe_pkg::NAME_LEN)
        begin
            if (c == LENGTH_FIELD[name_pos])
                name_pos++;
            else
                name_pos = (c == LENGTH_FIELD[0]) ? 1 : 0;
        end
        else if (name_pos == hbwe_pkg::NAME_LEN)
            name_pos = hbwe_pkg::NAME_LEN + 1;
        else
        begin
            name_pos  = 0;
            in_digits = 1'b1;
        end
    endfunction

    // Header byte: digit accumulation, name search, line tracking, slice setup
    function automatic void scan_header(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] idx;
        bit          hdr_end;
        if (in_digits)
        begin
            if (c >= hbwe_pkg::CHAR_ZERO && c <= hbwe_pkg::CHAR_NINE)
            begin
                d = c - hbwe_pkg::CHAR_ZERO;
                if (body_len > (LEN_MAX - d) / 10)
                    body_len = LEN_MAX;
                else
                    body_len = body_len * 10 + d;
            end
            else
            begin
                in_digits = 1'b0;
                if (body_len == 0)
                    track_name(c);
            end
        end
        else if (body_len == 0)
            track_name(c);

        if (c == hbwe_pkg::CHAR_LF)
        begin
            hdr_end  = (line_len == 1);
            line_len = 0;
            if (hdr_end)
            begin
                n         = slots_used(slot_count_reg);
                idx       = slot_index_reg;
                in_digits = 1'b0;
                name_pos  = 0;
                if (body_len == 0)
                    exp_phase = hbwe_pkg::PH_ERROR;
                else
                begin
                    slice_len = body_len / n;
                    if (idx != 0 && slice_len > LEN_MAX / idx)
                        slice_start = LEN_MAX;
                    else
                        slice_start = slice_len * idx;
                    body_pos = 0;
                    if (slice_len == 0)
                        exp_phase = hbwe_pkg::PH_DONE;
                    else if (slice_start == 0)
                        exp_phase = hbwe_pkg::PH_PASS;
                    else
                        exp_phase = hbwe_pkg::PH_SKIP;
                end
            end
        end
        else if (line_len < 2)
            line_len++;
    endfunction

    // Predict the result of one accepted byte
    function automatic slice_res_t extract_step(input logic [7:0] c);
        slice_res_t r;
        r = '0;
        case (exp_phase)
            hbwe_pkg::PH_HEADER: scan_header(c);
            hbwe_pkg::PH_SKIP:
            begin
                body_pos++;
                if (body_pos >= slice_start)
                begin
                    body_pos  = 0;
                    exp_phase = hbwe_pkg::PH_PASS;
                end
            end
            hbwe_pkg::PH_PASS:
            begin
                r.valid = 1'b1;
                r.data  = c;
                body_pos++;
                if (body_pos >= slice_len)
                begin
                    r.last    = 1'b1;
                    exp_phase = hbwe_pkg::PH_DONE;
                end
            end
            hbwe_pkg::PH_DONE: ;
            default: exp_phase = hbwe_pkg::PH_ERROR;
        endcase
        r.ph = exp_phase;
        return r;
    endfunction

    // Random byte that never ends a line
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == hbwe_pkg::CHAR_LF) ? CHAR_CR : b;
    endfunction

    // Queue a junk header line, sometimes opening with a broken field name
    function automatic void queue_junk_line();
        int cut;
        int n;
        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, hbwe_pkg::NAME_LEN - 1);
            for (int i = 0; i < cut; i++)
                line_q.push_back(LENGTH_FIELD[i]);
        end
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            line_q.push_back(junk_byte());
        line_q.push_back(CHAR_CR);
        line_q.push_back(hbwe_pkg::CHAR_LF);
    endfunction

    // Queue a length field line with two arbitrary separator bytes
    function automatic void queue_length_line(input string digits);
        for (int i = 0; i < hbwe_pkg::NAME_LEN; i++)
            line_q.push_back(LENGTH_FIELD[i]);
        line_q.push_back(junk_byte());
        line_q.push_back(junk_byte());
        for (int i = 0; i < digits.len(); i++)
            line_q.push_back(digits[i]);
        line_q.push_back(CHAR_CR);
        line_q.push_back(hbwe_pkg::CHAR_LF);
    endfunction

    // Offer one byte and hold it until accepted; valid stays high on return
    task automatic send_req(input logic [7:0] b, input logic typed, input slice_res_t row_res);
        slice_res_t pred;
        while ($urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = extract_step(b);
        pending_res_q.push_back(typed ? row_res : pred);
        n_sent++;
        // swap idle rates, then run flat out
        if (n_sent < 140)
        begin
            tx_pct = 33;
            rx_pct = 55;
        end
        else if (n_sent < 280)
        begin
            tx_pct = 55;
            rx_pct = 33;
        end
        else
        begin
            tx_pct = 0;
            rx_pct = 0;
        end
        @(negedge clk);
    endtask

    task automatic send_line();
        while (line_q.size() != 0)
            send_req(line_q.pop_front(), 1'b0, '0);
    endtask

    // Write a register once every request has its result
    task automatic write_reg(input logic [hbwe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hbwe_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_res_q.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == hbwe_pkg::CFG_SLOT_COUNT)
            slot_count_reg = val;
        else
            slot_index_reg = val[3:0];
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            err_count++;
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Drive the result stall: random idling plus the long hold-off
    always @(negedge clk)
        result_stall <= hold_on || ($urandom_range(0, 99) < rx_pct);

    // Hold off the result side long enough to fill the block
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_res_q.size() == 0)
            begin
                err_count++;
                $error("unexpected result: out_byte %0h phase %0d", out_byte, phase);
            end
            else
            begin
                want_res = pending_res_q.pop_front();
                check_field("out_byte", want_res.data, out_byte);
                check_field("out_valid", want_res.valid, out_valid);
                check_field("out_last", want_res.last, out_last);
                check_field("phase", want_res.ph, phase);
            end
        end
    end

    // Stop a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        hdr_case_t   hc;
        int          roll;
        int          cnt;
        int          idx;
        int          body_n;
        logic [63:0] len;
        logic [63:0] need;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        err_count    = 0;
        n_sent       = 0;
        tx_pct       = 33;
        rx_pct       = 55;

        exp_phase      = hbwe_pkg::PH_HEADER;
        name_pos       = 0;
        in_digits      = 1'b0;
        line_len       = 0;
        body_len       = '0;
        slice_len      = '0;
        slice_start    = '0;
        body_pos       = '0;
        slot_count_reg = 5'd2;
        slot_index_reg = 4'd0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIR_TABLE[i])
            send_req(DIR_TABLE[i].b, DIR_TABLE[i].typed, DIR_TABLE[i].res);

        // walk the registers through their extremes while the header runs
        write_reg(hbwe_pkg::CFG_SLOT_COUNT, 5'd31);
        write_reg(hbwe_pkg::CFG_SLOT_INDEX, 5'd15);
        repeat ($urandom_range(2, 4)) queue_junk_line();
        send_line();
        write_reg(hbwe_pkg::CFG_SLOT_COUNT, 5'd0);
        write_reg(hbwe_pkg::CFG_SLOT_INDEX, 5'd16);
        repeat ($urandom_range(1, 3)) queue_junk_line();
        send_line();

        // pick the header shape for this run
        roll = $urandom_range(0, 99);
        hc = (roll < 50) ? HC_NORMAL :
             (roll < 62) ? HC_PAST_END :
             (roll < 74) ? HC_ZERO_SLICE :
             (roll < 87) ? HC_NO_LENGTH : HC_OVERFLOW;
        case (hc)
            HC_NORMAL:
            begin
                cnt = $urandom_range(0, 31);
                idx = $urandom_range(0, slots_used(cnt) - 1);
                len = $urandom_range(slots_used(cnt), 320);
            end
            HC_PAST_END:
            begin
                cnt = $urandom_range(1, 4);
                idx = $urandom_range(cnt, 15);
                len = $urandom_range(cnt, 20);
            end
            HC_ZERO_SLICE:
            begin
                cnt = $urandom_range(2, 31);
                idx = $urandom_range(0, 15);
                len = $urandom_range(1, slots_used(cnt) - 1);
            end
            default:
            begin
                cnt = $urandom_range(0, 31);
                idx = $urandom_range(0, 15);
                len = 0;
            end
        endcase
        if (hc == HC_OVERFLOW)
            idx = $urandom_range(0, 1);

        write_reg(hbwe_pkg::CFG_SLOT_COUNT, 5'(cnt));
        write_reg(hbwe_pkg::CFG_SLOT_INDEX, 5'(idx + 16 * $urandom_range(0, 1)));

        // a zero length first leaves the search running
        if ($urandom_range(0, 1))
            queue_length_line("00");
        if (hc == HC_OVERFLOW)
            queue_length_line($sformatf("%0d%0d%0d", $urandom_range(1, 9),
                                        $urandom_range(100000000, 999999999),
                                        $urandom_range(100000000, 999999999)));
        else if (hc != HC_NO_LENGTH)
            queue_length_line($urandom_range(0, 1) ? $sformatf("%06d", len)
                                                   : $sformatf("%0d", len));
        // a later length is ignored once one is found
        if ($urandom_range(0, 1))
            queue_length_line("7");
        queue_junk_line();
        // one-character line ends the header
        line_q.push_back(($urandom_range(0, 3) == 0) ? junk_byte() : CHAR_CR);
        line_q.push_back(hbwe_pkg::CHAR_LF);
        send_line();

        // size the body to run through the slice and past it
        need = 16;
        if (exp_phase == hbwe_pkg::PH_SKIP || exp_phase == hbwe_pkg::PH_PASS)
            need += (slice_start + slice_len > BODY_CAP) ? BODY_CAP : slice_start + slice_len;
        body_n = (n_sent + need < ITEM_TARGET) ? ITEM_TARGET - n_sent : int'(need);
        hold_go = 1'b1;
        repeat (body_n) send_req(8'($urandom_range(0, 255)), 1'b0, '0);
        in_valid <= 1'b0;

        while (pending_res_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_res_q.size() == 0 && err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[http_body_window_extractor.f]
hw/rtl/hbwe_pkg.sv
hw/rtl/hbwe_slice_calc.sv
hw/rtl/http_body_window_extractor.sv
test/tb_top.sv
